FILE: hw/rtl/sec_pkg.sv
// sec_pkg: shared types, widths and register codes for the soft edge crop pixel unit
// no dependencies; imported by every module of the block
`default_nettype none

package sec_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int CHAN_W       = 16;
	localparam int POS_W        = 16;
	localparam int EDGE_W       = 20;
	localparam int SOFT_W       = 14;
	localparam int DIST_W       = 21;
	localparam int T_W          = 13;
	localparam int SQ_W         = 2 * T_W;
	localparam int SS_W         = 2 * SOFT_W;
	localparam int QUO_W        = 16;
	localparam int WEIGHT_W     = QUO_W + 1;
	localparam int NUM_W        = SS_W + QUO_W;
	localparam int PROD_W       = 2 * QUO_W + 1;
	localparam int PROD_SHIFT   = 2 * QUO_W;
	localparam int CFG_IDX_W    = 3;

	localparam int AXIS_STAGES  = 22;
	localparam int MERGE_STAGE  = AXIS_STAGES + 1;
	localparam int PIPE_DEPTH   = MERGE_STAGE + 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << QUO_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECT_LEFT,
		REG_RECT_RIGHT,
		REG_RECT_BOTTOM,
		REG_RECT_TOP,
		REG_EDGE_SOFTNESS,
		REG_BLACK_OUTSIDE
	} cfg_reg_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [CHAN_W-1:0]       in_chan0;
		logic [CHAN_W-1:0]       in_chan1;
		logic [CHAN_W-1:0]       in_chan2;
		logic [CHAN_W-1:0]       in_chan3;
	} pixel_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_chan0;
		logic [CHAN_W-1:0] out_chan1;
		logic [CHAN_W-1:0] out_chan2;
		logic [CHAN_W-1:0] out_chan3;
	} pixel_out_t;

	typedef struct packed {
		logic border;
		logic dpos;
		logic dge;
	} axis_flags_t;

	typedef struct packed {
		logic zero;
		logic pass;
	} merge_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/soft_edge_crop_pixel_unit.sv
// soft_edge_crop_pixel_unit: feathered crop of one pixel per beat, top level
// depends on sec_pkg, sec_axis_lane, sec_merge, sec_chan_lane
//
//   channel  | beat signals                        | payload
//   ---------+-------------------------------------+------------------------
//   in       | in_valid, in_stall                  | in_pixel (pixel_in_t)
//   out      | out_valid, out_stall                | out_pixel (pixel_out_t)
//   cfg      | cfg_we (no handshake)               | cfg_index, cfg_data
//
// one pixel per cycle sustained unless out_stall fills the output buffer
// pipeline depth is set mostly by the 16-stage quotient pipeline in each axis lane
// arst_n clears stage valids, the output buffer valids and the crop registers
// out_stall is absorbed by a two-entry output buffer; in_stall is its full flag
`default_nettype none

module soft_edge_crop_pixel_unit import sec_pkg::*; #(
	parameter int CHANNELS     = 4,
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire pixel_in_t            in_pixel,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output pixel_out_t                out_pixel,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [EDGE_W-1:0]    cfg_data
);

	logic signed [EDGE_W-1:0] rect_left_q, rect_right_q, rect_bottom_q, rect_top_q;
	logic [SOFT_W-1:0]        softness_q;
	logic                     black_q;
	logic [SS_W-1:0]          soft_sq_q;

	logic                  adv;
	logic [PIPE_DEPTH:1]   valid_q;
	logic [WEIGHT_W-1:0]   weight_x, weight_y;
	axis_flags_t           flags_x, flags_y;
	logic [PROD_W-1:0]     prod_s23;
	merge_ctrl_t           ctrl_s23;

	logic [CHAN_W-1:0] in_chan   [MAX_CHANNELS];
	logic [CHAN_W-1:0] res_chan  [MAX_CHANNELS];
	pixel_out_t        res_pixel;
	pixel_out_t        skid_q;
	logic              skid_valid_q;
	logic              take_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= '0;
			rect_right_q  <= '0;
			rect_bottom_q <= '0;
			rect_top_q    <= '0;
			softness_q    <= '0;
			black_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RECT_LEFT:     rect_left_q   <= cfg_data;
				REG_RECT_RIGHT:    rect_right_q  <= cfg_data;
				REG_RECT_BOTTOM:   rect_bottom_q <= cfg_data;
				REG_RECT_TOP:      rect_top_q    <= cfg_data;
				REG_EDGE_SOFTNESS: softness_q    <= cfg_data[SOFT_W-1:0];
				REG_BLACK_OUTSIDE: black_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_sq_q <= '0;
		end else begin
			soft_sq_q <= SS_W'(softness_q) * SS_W'(softness_q);
		end
	end

	// whole pipeline moves unless the output buffer is full
	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[PIPE_DEPTH-1:1], in_valid};
		end
	end

	sec_axis_lane u_lane_x (
		.clk        (clk),
		.adv        (adv),
		.pos        (in_pixel.pos_x),
		.lo_edge    (rect_left_q),
		.hi_edge    (rect_right_q),
		.softness   (softness_q),
		.soft_sq    (soft_sq_q),
		.weight_s22 (weight_x),
		.flags_s22  (flags_x)
	);

	sec_axis_lane u_lane_y (
		.clk        (clk),
		.adv        (adv),
		.pos        (in_pixel.pos_y),
		.lo_edge    (rect_bottom_q),
		.hi_edge    (rect_top_q),
		.softness   (softness_q),
		.soft_sq    (soft_sq_q),
		.weight_s22 (weight_y),
		.flags_s22  (flags_y)
	);

	sec_merge u_merge (
		.clk           (clk),
		.adv           (adv),
		.weight_x      (weight_x),
		.weight_y      (weight_y),
		.flags_x       (flags_x),
		.flags_y       (flags_y),
		.black_outside (black_q),
		.fade_off      (softness_q == '0),
		.prod_s23      (prod_s23),
		.ctrl_s23      (ctrl_s23)
	);

	assign in_chan[0] = in_pixel.in_chan0;
	assign in_chan[1] = in_pixel.in_chan1;
	assign in_chan[2] = in_pixel.in_chan2;
	assign in_chan[3] = in_pixel.in_chan3;

	genvar k;
	generate
		for (k = 0; k < MAX_CHANNELS; k++) begin : g_chan
			if (k < CHANNELS) begin : g_lane
				logic [CHANNEL_BITS-1:0] lane_res;

				sec_chan_lane #(
					.CHANNEL_BITS (CHANNEL_BITS)
				) u_chan (
					.clk        (clk),
					.adv        (adv),
					.chan       (in_chan[k][CHANNEL_BITS-1:0]),
					.prod_s23   (prod_s23),
					.ctrl_s23   (ctrl_s23),
					.result_s24 (lane_res)
				);

				assign res_chan[k] = CHAN_W'(lane_res);
			end else begin : g_unused
				assign res_chan[k] = '0;
			end
		end
	endgenerate

	assign res_pixel.out_chan0 = res_chan[0];
	assign res_pixel.out_chan1 = res_chan[1];
	assign res_pixel.out_chan2 = res_chan[2];
	assign res_pixel.out_chan3 = res_chan[3];

	// output register plus skid entry
	assign take_out = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take_out) begin
				skid_valid_q <= 1'b0;
			end
		end else if (valid_q[PIPE_DEPTH]) begin
			if (out_valid && !take_out) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid <= 1'b1;
			end
		end else if (take_out) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take_out) begin
				out_pixel <= skid_q;
			end
		end else if (valid_q[PIPE_DEPTH]) begin
			if (out_valid && !take_out) begin
				skid_q <= res_pixel;
			end else begin
				out_pixel <= res_pixel;
			end
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid)
		else $error("skid entry held without a pending output beat");

	a_free_out_frees_in: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |=> !in_stall)
		else $error("input stalled after an unstalled output cycle");

	a_zero_lane0: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[MERGE_STAGE] && adv && ctrl_s23.zero |=> res_pixel.out_chan0 == '0)
		else $error("zeroed pixel produced a nonzero channel");

	a_band_weight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[AXIS_STAGES] && (softness_q != '0) && flags_x.dpos && !flags_x.dge
		|-> weight_x < WEIGHT_ONE)
		else $error("in-band weight reached full scale");

endmodule

`default_nettype wire

FILE: hw/rtl/sec_axis_lane.sv
// sec_axis_lane: edge distance, border test and smoothstep weight for one axis
// depends on sec_pkg; holds a pipelined restoring divider, one quotient bit per stage
`default_nettype none

module sec_axis_lane import sec_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     adv,
	input  wire logic signed [POS_W-1:0]  pos,
	input  wire logic signed [EDGE_W-1:0] lo_edge,
	input  wire logic signed [EDGE_W-1:0] hi_edge,
	input  wire logic [SOFT_W-1:0]        softness,
	input  wire logic [SS_W-1:0]          soft_sq,
	output logic [WEIGHT_W-1:0]           weight_s22,
	output axis_flags_t                   flags_s22
);

	localparam int RND_W = DIST_W - 4;
	localparam int DIV_W = SS_W + 1;

	logic signed [DIST_W-1:0] pos_fix, lo_ext, hi_ext, lo_rnd, hi_rnd;
	logic [RND_W:0]           hi_last;
	logic                     border_now;

	logic signed [DIST_W-1:0] a_s1, b_s1, d_s2;
	logic                     border_s1, border_s2;

	logic signed [DIST_W-1:0] soft_ext;
	logic [DIST_W:0]          d_dbl;
	logic                     first_half;
	logic [SOFT_W-1:0]        t_far;
	logic [T_W-1:0]           t_s3;
	logic [SQ_W-1:0]          sq_s4;
	logic [NUM_W-1:0]         num;

	axis_flags_t flags_p [3:AXIS_STAGES-1];
	logic        near_p  [3:AXIS_STAGES-1];

	logic [SS_W-1:0]  rem_p [0:QUO_W-1];
	logic [QUO_W-1:0] low_p [0:QUO_W-1];
	logic [QUO_W-1:0] quo_p [0:QUO_W];

	// pixel-rounded edges, halves up
	assign pos_fix = {{(DIST_W-POS_W-4){pos[POS_W-1]}}, pos, 4'b0000};
	assign lo_ext  = {{(DIST_W-EDGE_W){lo_edge[EDGE_W-1]}}, lo_edge};
	assign hi_ext  = {{(DIST_W-EDGE_W){hi_edge[EDGE_W-1]}}, hi_edge};
	assign lo_rnd  = lo_ext + DIST_W'(8);
	assign hi_rnd  = hi_ext + DIST_W'(8);
	assign hi_last = {hi_rnd[DIST_W-1], hi_rnd[DIST_W-1:4]} - (RND_W+1)'(1);
	assign border_now = ({pos[POS_W-1], pos} == lo_rnd[DIST_W-1:4]) ||
		({pos[POS_W-1], pos[POS_W-1], pos} == hi_last);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1      <= pos_fix - lo_ext;
			b_s1      <= hi_ext - pos_fix;
			border_s1 <= border_now;
			d_s2      <= (a_s1 < b_s1) ? a_s1 : b_s1;
			border_s2 <= border_s1;
		end
	end

	// band classification and folded distance
	assign soft_ext   = {{(DIST_W-SOFT_W){1'b0}}, softness};
	assign d_dbl      = {d_s2, 1'b0};
	assign first_half = d_dbl < (DIST_W+1)'(softness);
	assign t_far      = softness - d_s2[SOFT_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_p[3].border <= border_s2;
			flags_p[3].dpos   <= !d_s2[DIST_W-1] && (d_s2 != '0);
			flags_p[3].dge    <= d_s2 >= soft_ext;
			near_p[3]         <= first_half;
			t_s3              <= first_half ? d_s2[T_W-1:0] : t_far[T_W-1:0];
			sq_s4             <= SQ_W'(t_s3) * SQ_W'(t_s3);
		end
	end

	genvar k;
	generate
		for (k = 4; k < AXIS_STAGES; k++) begin : g_flag_line
			always_ff @(posedge clk) begin
				if (adv) begin
					flags_p[k] <= flags_p[k-1];
					near_p[k]  <= near_p[k-1];
				end
			end
		end
	endgenerate

	// upper half uses a ceiling, so bias the dividend by ss - 1
	assign num = NUM_W'({sq_s4, {WEIGHT_W{1'b0}}}) +
		(near_p[4] ? '0 : (NUM_W'(soft_sq) - NUM_W'(1)));

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_p[0] <= num[NUM_W-1:QUO_W];
			low_p[0] <= num[QUO_W-1:0];
			quo_p[0] <= '0;
		end
	end

	genvar j;
	generate
		for (j = 0; j < QUO_W; j++) begin : g_div
			logic [DIV_W-1:0] trial, diff;
			logic             take;

			assign trial = {rem_p[j], low_p[j][QUO_W-1]};
			assign take  = trial >= {1'b0, soft_sq};
			assign diff  = trial - {1'b0, soft_sq};

			always_ff @(posedge clk) begin
				if (adv) begin
					quo_p[j+1] <= {quo_p[j][QUO_W-2:0], take};
				end
			end

			if (j < QUO_W - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (adv) begin
						rem_p[j+1] <= take ? diff[SS_W-1:0] : trial[SS_W-1:0];
						low_p[j+1] <= {low_p[j][QUO_W-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s22 <= flags_p[AXIS_STAGES-1];
			if (!flags_p[AXIS_STAGES-1].dpos) begin
				weight_s22 <= '0;
			end else if (flags_p[AXIS_STAGES-1].dge) begin
				weight_s22 <= WEIGHT_ONE;
			end else if (near_p[AXIS_STAGES-1]) begin
				weight_s22 <= WEIGHT_W'(quo_p[QUO_W]);
			end else begin
				weight_s22 <= WEIGHT_ONE - WEIGHT_W'(quo_p[QUO_W]);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sec_merge.sv
// sec_merge: combines the two axis lanes into a fade product and zero/pass control
// depends on sec_pkg; fed by two sec_axis_lane instances
`default_nettype none

module sec_merge import sec_pkg::*; (
	input  wire logic                clk,
	input  wire logic                adv,
	input  wire logic [WEIGHT_W-1:0] weight_x,
	input  wire logic [WEIGHT_W-1:0] weight_y,
	input  wire axis_flags_t         flags_x,
	input  wire axis_flags_t         flags_y,
	input  wire logic                black_outside,
	input  wire logic                fade_off,
	output logic [PROD_W-1:0]        prod_s23,
	output merge_ctrl_t              ctrl_s23
);

	logic zero_now;

	assign zero_now = black_outside && (flags_x.border || flags_y.border ||
		!flags_x.dpos || !flags_y.dpos);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s23      <= PROD_W'(weight_x) * PROD_W'(weight_y);
			ctrl_s23.zero <= zero_now;
			ctrl_s23.pass <= !zero_now && (fade_off || (flags_x.dge && flags_y.dge));
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sec_chan_lane.sv
// sec_chan_lane: one channel lane, delays the channel value and zeroes, passes or scales it by the fade product
// depends on sec_pkg; product and control come from sec_merge
`default_nettype none

module sec_chan_lane import sec_pkg::*; #(
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    adv,
	input  wire logic [CHANNEL_BITS-1:0] chan,
	input  wire logic [PROD_W-1:0]       prod_s23,
	input  wire merge_ctrl_t             ctrl_s23,
	output logic [CHANNEL_BITS-1:0]      result_s24
);

	localparam int FULL_W = CHANNEL_BITS + PROD_W;

	logic [CHANNEL_BITS-1:0] chan_p [1:MERGE_STAGE];
	logic [FULL_W-1:0]       scaled;

	always_ff @(posedge clk) begin
		if (adv) begin
			chan_p[1] <= chan;
		end
	end

	genvar k;
	generate
		for (k = 2; k <= MERGE_STAGE; k++) begin : g_delay
			always_ff @(posedge clk) begin
				if (adv) begin
					chan_p[k] <= chan_p[k-1];
				end
			end
		end
	endgenerate

	assign scaled = FULL_W'(chan_p[MERGE_STAGE]) * FULL_W'(prod_s23);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctrl_s23.zero) begin
				result_s24 <= '0;
			end else if (ctrl_s23.pass) begin
				result_s24 <= chan_p[MERGE_STAGE];
			end else begin
				result_s24 <= scaled[PROD_SHIFT +: CHANNEL_BITS];
			end
		end
	end

endmodule

`default_nettype wire

FILE: bench/tb_soft_edge_crop_pixel_unit.sv
// tb_soft_edge_crop_pixel_unit: self-checking bench for the feathered crop pixel unit
// drives pixels and crop settings, predicts each output pixel and compares per channel
// depends on sec_pkg and soft_edge_crop_pixel_unit
`timescale 1ns / 1ps

module tb_soft_edge_crop_pixel_unit;
	import sec_pkg::*;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	pixel_in_t            in_pixel = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	pixel_out_t           out_pixel;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [EDGE_W-1:0]    cfg_data = '0;

	// crop settings as the block should hold them
	int crop_left, crop_right, crop_bottom, crop_top, crop_soft;
	bit crop_black;

	pixel_out_t exp_pixels[$];
	int err_count = 0;
	bit gaps_on = 1'b1;
	int burst_left = 0;
	int hold_req = 0;

	soft_edge_crop_pixel_unit #(
		.CHANNELS(4),
		.CHANNEL_BITS(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_pixel(in_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_pixel(out_pixel),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int edge_px(int e);
		return (e + 8) >>> 4;
	endfunction

	// smoothstep fade gain of one axis, 65536 is unity
	function automatic longint fade_gain(int d, int s);
		longint sq, num, r;
		if (d >= s) return 64'd65536;
		if (d <= 0) return 64'd0;
		sq = longint'(s) * longint'(s);
		if (2 * d < s) begin
			num = longint'(d) * longint'(d) * 131072;
			return num / sq;
		end
		r = longint'(s - d);
		num = r * r * 131072;
		return 65536 - (num + sq - 1) / sq;
	endfunction

	function automatic pixel_out_t crop_pixel(pixel_in_t p);
		int x, y, fx, fy, a, b, dx, dy;
		bit zero, pass;
		longint gx, gy;
		longint chans[4];
		longint res[4];
		pixel_out_t o;
		x = int'(p.pos_x);
		y = int'(p.pos_y);
		fx = x * 16;
		fy = y * 16;
		a = fx - crop_left;
		b = crop_right - fx;
		dx = (a < b) ? a : b;
		a = fy - crop_bottom;
		b = crop_top - fy;
		dy = (a < b) ? a : b;
		zero = 1'b0;
		pass = 1'b0;
		gx = 65536;
		gy = 65536;
		if (crop_black && (x == edge_px(crop_left) || x == edge_px(crop_right) - 1 ||
				y == edge_px(crop_bottom) || y == edge_px(crop_top) - 1 ||
				dx <= 0 || dy <= 0))
			zero = 1'b1;
		if (!zero) begin
			if (crop_soft == 0 || (dx >= crop_soft && dy >= crop_soft)) begin
				pass = 1'b1;
			end else begin
				gx = fade_gain(dx, crop_soft);
				gy = fade_gain(dy, crop_soft);
			end
		end
		chans[0] = longint'(p.in_chan0);
		chans[1] = longint'(p.in_chan1);
		chans[2] = longint'(p.in_chan2);
		chans[3] = longint'(p.in_chan3);
		for (int k = 0; k < 4; k++) begin
			if (zero)
				res[k] = 0;
			else if (pass)
				res[k] = chans[k];
			else
				res[k] = (chans[k] * (gx * gy)) >>> 32;
		end
		o.out_chan0 = res[0][15:0];
		o.out_chan1 = res[1][15:0];
		o.out_chan2 = res[2][15:0];
		o.out_chan3 = res[3][15:0];
		return o;
	endfunction

	task automatic check_chan(int k, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: out_chan%0d expected %h got %h", $time, k, want, got);
		end
	endtask

	always @(posedge clk) begin
		pixel_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_pixels.size() == 0) begin
				err_count++;
				$display("%0t: output beat with no pixel pending, expected none got %h",
					$time, out_pixel);
			end else begin
				want = exp_pixels.pop_front();
				check_chan(0, want.out_chan0, out_pixel.out_chan0);
				check_chan(1, want.out_chan1, out_pixel.out_chan1);
				check_chan(2, want.out_chan2, out_pixel.out_chan2);
				check_chan(3, want.out_chan3, out_pixel.out_chan3);
			end
		end
	end

	// receiver stall pattern, with long hold-offs on request
	initial begin : out_stall_gen
		int seg_left;
		int hold_left;
		stall_mode_t mode;
		seg_left = 0;
		hold_left = 0;
		mode = STALL_NONE;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(10, 150);
					mode = stall_mode_t'($urandom_range(0, 3));
				end
				seg_left--;
				case (mode)
					STALL_NONE: out_stall = 1'b0;
					STALL_LIGHT: out_stall = ($urandom_range(0, 9) < 3);
					STALL_HEAVY: out_stall = ($urandom_range(0, 9) < 7);
					default: out_stall = ~out_stall;
				endcase
			end
		end
	end

	task automatic send_pixel(input pixel_in_t p);
		@(negedge clk);
		in_valid = 1'b1;
		in_pixel = p;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		exp_pixels.push_back(crop_pixel(p));
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 32);
				@(negedge clk);
				in_valid = 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain_and_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (exp_pixels.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[EDGE_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_RECT_LEFT: crop_left = int'($signed(value[EDGE_W-1:0]));
			REG_RECT_RIGHT: crop_right = int'($signed(value[EDGE_W-1:0]));
			REG_RECT_BOTTOM: crop_bottom = int'($signed(value[EDGE_W-1:0]));
			REG_RECT_TOP: crop_top = int'($signed(value[EDGE_W-1:0]));
			REG_EDGE_SOFTNESS: crop_soft = value & 32'h3FFF;
			REG_BLACK_OUTSIDE: crop_black = value[0];
			default: ;
		endcase
	endtask

	task automatic set_crop(int l, int r, int b, int t, int s, int bo);
		write_reg(REG_RECT_LEFT, l);
		write_reg(REG_RECT_RIGHT, r);
		write_reg(REG_RECT_BOTTOM, b);
		write_reg(REG_RECT_TOP, t);
		write_reg(REG_EDGE_SOFTNESS, s);
		write_reg(REG_BLACK_OUTSIDE, bo);
	endtask

	function automatic int clamp_edge(int v);
		if (v < -524288) return -524288;
		if (v > 524287) return 524287;
		return v;
	endfunction

	function automatic pixel_in_t make_pixel(int x, int y);
		pixel_in_t p;
		p.pos_x = x[POS_W-1:0];
		p.pos_y = y[POS_W-1:0];
		p.in_chan0 = 16'hFFFF;
		p.in_chan1 = 16'h8001;
		p.in_chan2 = 16'h1234;
		p.in_chan3 = 16'h00FF;
		return p;
	endfunction

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	// coordinate near the low or high edge of an axis, inside it, or anywhere
	function automatic logic [POS_W-1:0] pick_coord(int lo_edge, int hi_edge);
		int e, span, lo, hi;
		span = crop_soft / 16 + 4;
		lo = edge_px(lo_edge);
		hi = edge_px(hi_edge);
		case ($urandom_range(0, 9))
			0, 1: return POS_W'($urandom);
			2: begin
				if (hi > lo)
					return POS_W'(lo + int'($urandom_range(0, hi - lo)));
				return POS_W'(lo);
			end
			3, 4, 5: e = lo;
			default: e = hi;
		endcase
		return POS_W'(e + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic pixel_in_t random_pixel();
		pixel_in_t p;
		p.pos_x = pick_coord(crop_left, crop_right);
		p.pos_y = pick_coord(crop_bottom, crop_top);
		p.in_chan0 = rand_chan();
		p.in_chan1 = rand_chan();
		p.in_chan2 = rand_chan();
		p.in_chan3 = rand_chan();
		return p;
	endfunction

	task automatic random_crop();
		int l, r, b, t, s, cx, cy, hw, hh;
		cx = int'($urandom_range(0, 65535)) - 32768;
		cy = int'($urandom_range(0, 65535)) - 32768;
		hw = $urandom_range(0, 6400);
		hh = $urandom_range(0, 6400);
		l = cx * 16 - hw + int'($urandom_range(0, 15));
		r = cx * 16 + hw;
		b = cy * 16 - hh + int'($urandom_range(0, 15));
		t = cy * 16 + hh;
		case ($urandom_range(0, 7))
			0: begin
				l = -524288;
				r = 524287;
				b = -524288;
				t = 524287;
			end
			1: begin
				cx = l;
				l = r;
				r = cx;
			end
			2: begin
				cy = b;
				b = t;
				t = cy;
			end
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0: s = 0;
			1: s = 16383;
			2: s = $urandom_range(1, 16);
			3: s = $urandom_range(1, 300);
			default: s = $urandom_range(1, 4000);
		endcase
		set_crop(clamp_edge(l), clamp_edge(r), clamp_edge(b), clamp_edge(t), s,
			$urandom_range(0, 1));
	endtask

	task automatic test_reset_defaults();
		pixel_in_t p;
		p = make_pixel(-32768, 32767);
		p.in_chan1 = 16'h0000;
		send_pixel(p);
		p = make_pixel(32767, -32768);
		p.in_chan0 = 16'h0000;
		p.in_chan3 = 16'hFFFF;
		send_pixel(p);
		p = make_pixel(0, 0);
		p.in_chan0 = 16'hA5A5;
		p.in_chan1 = 16'h5A5A;
		send_pixel(p);
		drain_and_idle();
	endtask

	task automatic test_black_border();
		// left edge 10.5 px, top edge 60.25 px
		set_crop(168, 800, 320, 964, 0, 1);
		send_pixel(make_pixel(10, 40));
		send_pixel(make_pixel(11, 40));
		send_pixel(make_pixel(49, 40));
		send_pixel(make_pixel(30, 20));
		send_pixel(make_pixel(30, 59));
		send_pixel(make_pixel(30, 40));
		drain_and_idle();
	endtask

	task automatic test_fade_band();
		set_crop(168, 800, 320, 964, 128, 0);
		send_pixel(make_pixel(10, 40));
		send_pixel(make_pixel(13, 40));
		send_pixel(make_pixel(16, 40));
		send_pixel(make_pixel(13, 22));
		send_pixel(make_pixel(30, 40));
		send_pixel(make_pixel(11, 40));
		drain_and_idle();
		write_reg(REG_BLACK_OUTSIDE, 1);
		send_pixel(make_pixel(12, 40));
		send_pixel(make_pixel(48, 58));
		drain_and_idle();
	endtask

	task automatic test_inverted_rect();
		set_crop(800, 168, 964, 320, 64, 0);
		send_pixel(make_pixel(30, 40));
		send_pixel(make_pixel(5, 70));
		drain_and_idle();
		write_reg(REG_EDGE_SOFTNESS, 0);
		send_pixel(make_pixel(30, 40));
		drain_and_idle();
		write_reg(REG_BLACK_OUTSIDE, 1);
		send_pixel(make_pixel(30, 40));
		drain_and_idle();
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 11; phase++) begin
			if (phase == 0)
				set_crop(-524288, 524287, -524288, 524287, 16383, 1);
			else
				random_crop();
			repeat (135) send_pixel(random_pixel());
			drain_and_idle();
		end
	endtask

	task automatic test_output_hold_off();
		set_crop(-800, 800, -640, 640, 200, 1);
		gaps_on = 1'b0;
		hold_req = 400;
		repeat (80) send_pixel(random_pixel());
		gaps_on = 1'b1;
		drain_and_idle();
	endtask

	initial begin
		crop_left = 0;
		crop_right = 0;
		crop_bottom = 0;
		crop_top = 0;
		crop_soft = 0;
		crop_black = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_reset_defaults();
		test_black_border();
		test_fade_band();
		test_inverted_rect();
		test_random_settings();
		test_output_hold_off();

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#1000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
